[sv/cbc_pkg.sv]
package cbc_pkg;

  localparam int MAX_MSG_BYTES = 16;
  localparam int MAX_RESENDS   = 5;
  localparam int TICK_W        = 20;
  localparam int BYTE_POS_W    = $clog2(MAX_MSG_BYTES + 1);
  localparam int BYTE_IDX_W    = $clog2(MAX_MSG_BYTES);
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 12;

  localparam logic [1:0] CMD_TICK  = 2'd0;
  localparam logic [1:0] CMD_WRITE = 2'd1;
  localparam logic [1:0] CMD_START = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OWN    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TICKS  = 2'd2;

  localparam logic [1:0] ST_NONE = 2'd0;
  localparam logic [1:0] ST_DONE = 2'd1;
  localparam logic [1:0] ST_FAIL = 2'd2;

  localparam logic [3:0] ADDR_ALL = 4'hf;

  typedef struct packed {
    logic [1:0] command;
    logic       line_level;
    logic [3:0] byte_slot;
    logic [7:0] byte_value;
    logic [4:0] frame_length;
  } in_t;

  typedef struct packed {
    logic       line_release;
    logic [1:0] send_status;
    logic       start_refused;
    logic       rx_valid;
    logic [7:0] rx_data;
    logic       rx_last;
  } out_t;

  typedef struct packed {
    logic [TICK_W-1:0] t3;
    logic [TICK_W-1:0] t6;
    logic [TICK_W-1:0] t8;
    logic [TICK_W-1:0] t9;
    logic [TICK_W-1:0] t12;
    logic [TICK_W-1:0] t15;
    logic [TICK_W-1:0] t18;
    logic [TICK_W-1:0] t23;
    logic [TICK_W-1:0] t34;
    logic [TICK_W-1:0] t37;
    logic [TICK_W-1:0] t40;
    logic [TICK_W-1:0] t42;
    logic [TICK_W-1:0] t58;
    logic [TICK_W-1:0] t72;
    logic [TICK_W-1:0] t120;
    logic [TICK_W-1:0] t4h;
    logic [TICK_W-1:0] t5mh;
    logic [TICK_W-1:0] t10h;
    logic [TICK_W-1:0] t14mh;
    logic [TICK_W-1:0] t19h;
    logic [TICK_W-1:0] t24h;
    logic [TICK_W-1:0] t28h;
  } tk_t;

endpackage

[sv/cbc_timing.sv]
module cbc_timing (
  input  logic [cbc_pkg::CFG_DATA_W-1:0] tpu_i,
  output cbc_pkg::tk_t                   tk_o
);
  import cbc_pkg::*;

  logic [TICK_W-1:0] t;
  logic [TICK_W-1:0] h;

  assign t = TICK_W'(tpu_i);
  assign h = TICK_W'(tpu_i >> 1);

  assign tk_o.t3    = t * TICK_W'(3);
  assign tk_o.t6    = t * TICK_W'(6);
  assign tk_o.t8    = t * TICK_W'(8);
  assign tk_o.t9    = t * TICK_W'(9);
  assign tk_o.t12   = t * TICK_W'(12);
  assign tk_o.t15   = t * TICK_W'(15);
  assign tk_o.t18   = t * TICK_W'(18);
  assign tk_o.t23   = t * TICK_W'(23);
  assign tk_o.t34   = t * TICK_W'(34);
  assign tk_o.t37   = t * TICK_W'(37);
  assign tk_o.t40   = t * TICK_W'(40);
  assign tk_o.t42   = t * TICK_W'(42);
  assign tk_o.t58   = t * TICK_W'(58);
  assign tk_o.t72   = t * TICK_W'(72);
  assign tk_o.t120  = t * TICK_W'(120);
  assign tk_o.t4h   = t * TICK_W'(4) + h;
  assign tk_o.t5mh  = t * TICK_W'(5) - h;
  assign tk_o.t10h  = t * TICK_W'(10) + h;
  assign tk_o.t14mh = t * TICK_W'(14) - h;
  assign tk_o.t19h  = t * TICK_W'(19) + h;
  assign tk_o.t24h  = t * TICK_W'(24) + h;
  assign tk_o.t28h  = t * TICK_W'(28) + h;

endmodule

[sv/cbc_outbuf.sv]
module cbc_outbuf (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  cbc_pkg::out_t data_i,
  output logic          full_o,
  output logic          valid_o,
  input  logic          ready_i,
  output cbc_pkg::out_t data_o
);
  import cbc_pkg::*;

  out_t       ent_q [2];
  logic [1:0] cnt_q;
  logic [1:0] cnt_d;
  logic       pop;

  assign pop     = valid_o && ready_i;
  assign valid_o = (cnt_q != 2'd0);
  assign full_o  = (cnt_q == 2'd2);
  assign data_o  = ent_q[0];

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop && !push_i) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i && !pop) begin
      ent_q[cnt_q[0]] <= data_i;
    end else if (pop && !push_i) begin
      ent_q[0] <= ent_q[1];
    end else if (pop && push_i) begin
      if (cnt_q == 2'd1) begin
        ent_q[0] <= data_i;
      end else begin
        ent_q[0] <= ent_q[1];
        ent_q[1] <= data_i;
      end
    end
  end

`ifndef SYNTHESIS
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q != 2'd3)
    else $error("output queue count out of range");
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (full_o && !pop) |-> !push_i)
    else $error("push into full output queue");
  a_cnt_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop) |=> cnt_q == $past(cnt_q) + 2'd1)
    else $error("output queue count did not advance");
`endif

endmodule

[sv/cbc_core.sv]
module cbc_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           acc_i,
  input  cbc_pkg::in_t                   item_i,
  input  logic                           cfg_we_i,
  input  logic [cbc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [cbc_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  cbc_pkg::tk_t                   tk_i,
  output logic [cbc_pkg::CFG_DATA_W-1:0] tpu_o,
  output cbc_pkg::out_t                  res_o
);
  import cbc_pkg::*;

  localparam logic [4:0] S_OFF = 5'd0, S_IDLE = 5'd1, S_I_FREE = 5'd2;
  localparam logic [4:0] S_I_START_LO = 5'd3, S_I_START_HI = 5'd4;
  localparam logic [4:0] S_I_HINIT_LO = 5'd5, S_I_HINIT_HI = 5'd6;
  localparam logic [4:0] S_I_HDST_LO = 5'd7, S_I_HDST_HI = 5'd8;
  localparam logic [4:0] S_I_DATA_LO = 5'd9, S_I_DATA_HI = 5'd10;
  localparam logic [4:0] S_I_EOM_LO = 5'd11, S_I_EOM_HI = 5'd12;
  localparam logic [4:0] S_I_ACK_LO = 5'd13, S_I_ACK_HI = 5'd14, S_I_ACK_CHK = 5'd15;
  localparam logic [4:0] S_F_START_LO = 5'd16, S_F_START_HI = 5'd17;
  localparam logic [4:0] S_F_HINIT_LO = 5'd18, S_F_HINIT_HI = 5'd19;
  localparam logic [4:0] S_F_HDST_LO = 5'd20, S_F_HDST_HI = 5'd21;
  localparam logic [4:0] S_F_EOM_LO = 5'd22, S_F_EOM_HI = 5'd23;
  localparam logic [4:0] S_F_ACK_LO = 5'd24, S_F_ACK_CHK = 5'd25, S_F_ACK_END = 5'd26;
  localparam logic [4:0] S_F_DATA_LO = 5'd27, S_F_DATA_HI = 5'd28;

  localparam logic [1:0] CAP_OFF = 2'd0, CAP_FALL = 2'd1, CAP_RISE = 2'd2;

  localparam logic [BYTE_POS_W-1:0] MAX_POS = BYTE_POS_W'(MAX_MSG_BYTES);
  localparam logic [2:0]            MAX_RS  = 3'(MAX_RESENDS);
  localparam logic [TICK_W-1:0]     CNT_MAX = {TICK_W{1'b1}};

  logic [4:0]            state_q, state_d;
  logic [TICK_W-1:0]     elapsed_q, elapsed_d, timeout_q, timeout_d, lowdur_q, lowdur_d;
  logic [1:0]            cap_q, cap_d;
  logic                  prev_q, prev_d;
  logic [7:0]            hdr_q, hdr_d, shift_q, shift_d;
  logic [2:0]            txbit_q, txbit_d, rxbit_q, rxbit_d, resend_q, resend_d;
  logic [BYTE_POS_W-1:0] txbyte_q, txbyte_d, rxbyte_q, rxbyte_d, pend_q, pend_d;
  logic                  ack_q, ack_d, eom_q, eom_d, nak_q, nak_d, drv_q, drv_d;
  logic [3:0]            own_q, own_d;
  logic [CFG_DATA_W-1:0] tpu_q, tpu_d;
  logic [7:0]            tx_buf_q [MAX_MSG_BYTES];

  logic [TICK_W-1:0]     el_inc;
  logic [TICK_W:0]       sum_s;
  logic                  lo_start, lo_zero, lo_one, sum_start, sum_bit;
  logic                  buf_we;
  logic                  buf_clr;

  assign tpu_o  = tpu_q;
  assign el_inc = (elapsed_q == CNT_MAX) ? elapsed_q : elapsed_q + TICK_W'(1);
  assign sum_s  = {1'b0, lowdur_q} + {1'b0, el_inc};

  assign lo_start  = (el_inc >= tk_i.t34) && (el_inc <= tk_i.t40);
  assign lo_zero   = (el_inc >= tk_i.t12) && (el_inc <= tk_i.t18);
  assign lo_one    = (el_inc >= tk_i.t3) && (el_inc <= tk_i.t9);
  assign sum_start = (sum_s <= {1'b0, tk_i.t58}) && (sum_s >= {1'b0, tk_i.t42});
  assign sum_bit   = (sum_s <= {1'b0, tk_i.t28h}) && (sum_s >= {1'b0, tk_i.t19h});

  assign buf_we = !cfg_we_i && acc_i && (item_i.command == CMD_WRITE) && (pend_q == '0)
                  && ({1'b0, item_i.byte_slot} < MAX_POS);
  assign buf_clr = cfg_we_i && (cfg_idx_i == CFG_ENABLE) && !cfg_data_i[0]
                   && (state_q != S_OFF);

  always_comb begin
    logic       go_en;
    logic [4:0] go_s;
    logic [4:0] s;
    logic       done;
    logic       hit;
    logic       fall;
    logic       rise;
    logic       tb;
    logic       at_end;
    logic       b;
    state_d  = state_q;  elapsed_d = elapsed_q; timeout_d = timeout_q;
    lowdur_d = lowdur_q; cap_d     = cap_q;     prev_d    = prev_q;
    hdr_d    = hdr_q;    shift_d   = shift_q;
    txbit_d  = txbit_q;  rxbit_d   = rxbit_q;   resend_d  = resend_q;
    txbyte_d = txbyte_q; rxbyte_d  = rxbyte_q;  pend_d    = pend_q;
    ack_d    = ack_q;    eom_d     = eom_q;     nak_d     = nak_q;   drv_d = drv_q;
    own_d    = own_q;    tpu_d     = tpu_q;
    res_o    = '0;
    go_en    = 1'b0;
    go_s     = state_q;
    done     = 1'b0;
    fall     = prev_q && !item_i.line_level;
    rise     = !prev_q && item_i.line_level;
    hit      = 1'b0;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_ENABLE: begin
          if (cfg_data_i[0] && state_q == S_OFF) begin
            go_en = 1'b1; go_s = S_IDLE;
          end else if (!cfg_data_i[0] && state_q != S_OFF) begin
            go_en = 1'b1; go_s = S_OFF;
          end
        end
        CFG_OWN:   own_d = cfg_data_i[3:0];
        CFG_TICKS: tpu_d = (cfg_data_i == '0) ? CFG_DATA_W'(1) : cfg_data_i;
        default: ;
      endcase
    end else if (acc_i) begin
      unique case (item_i.command)
        CMD_TICK: begin
          prev_d    = item_i.line_level;
          elapsed_d = el_inc;
          if (state_q != S_OFF) begin
            hit = (cap_q == CAP_FALL && fall) || (cap_q == CAP_RISE && rise);
            if (hit) begin
              done = 1'b1;
              unique case (state_q)
                S_IDLE: begin
                  go_en = 1'b1; go_s = S_F_START_LO;
                end
                S_I_FREE, S_I_START_HI, S_I_HINIT_HI: begin
                  txbit_d = '0; txbyte_d = '0;
                  go_en = 1'b1; go_s = S_F_START_LO;
                end
                S_F_START_LO: begin
                  go_en = 1'b1;
                  if (lo_start) begin
                    lowdur_d = el_inc; go_s = S_F_START_HI;
                  end else begin
                    go_s = S_IDLE;
                  end
                end
                S_F_START_HI: begin
                  go_en = 1'b1; go_s = sum_start ? S_F_HINIT_LO : S_IDLE;
                end
                S_F_HINIT_LO, S_F_HDST_LO, S_F_DATA_LO, S_F_EOM_LO: begin
                  go_en = 1'b1;
                  if (lo_zero || lo_one) begin
                    lowdur_d = el_inc;
                    if (state_q == S_F_EOM_LO) begin
                      eom_d = !lo_zero;
                    end else begin
                      shift_d = {shift_q[6:0], !lo_zero};
                    end
                    go_s = state_q + 5'd1;
                  end else begin
                    go_s = S_IDLE;
                  end
                end
                S_F_HINIT_HI, S_F_HDST_HI, S_F_DATA_HI: begin
                  go_en = 1'b1;
                  if (!sum_bit) begin
                    go_s = S_IDLE;
                  end else begin
                    rxbit_d = rxbit_q + 3'd1;
                    if (rxbit_d == 3'd0) begin
                      if (rxbyte_q == '0) hdr_d = shift_q;
                      if (rxbyte_q < MAX_POS) rxbyte_d = rxbyte_q + BYTE_POS_W'(1);
                    end
                    if (state_q == S_F_HINIT_HI) begin
                      go_s = (rxbit_d == 3'd4) ? S_F_HDST_LO : S_F_HINIT_LO;
                    end else if (rxbit_d == 3'd0) begin
                      go_s = S_F_EOM_LO;
                    end else begin
                      go_s = (state_q == S_F_HDST_HI) ? S_F_HDST_LO : S_F_DATA_LO;
                    end
                  end
                end
                S_F_EOM_HI: begin
                  go_en = 1'b1; go_s = sum_bit ? S_F_ACK_LO : S_IDLE;
                end
                S_F_ACK_LO: begin
                  go_en = 1'b1; go_s = S_F_ACK_END;
                end
                S_F_ACK_END: begin
                  go_en = 1'b1; go_s = S_F_DATA_LO;
                end
                default: done = 1'b0;
              endcase
            end
            if (!done && timeout_q != '0 && el_inc >= timeout_q
                && state_q != S_IDLE) begin
              go_en = 1'b1;
              if (state_q >= S_F_START_LO) begin
                if (state_q == S_F_ACK_LO) go_s = S_F_ACK_CHK;
                else if (state_q == S_F_ACK_CHK) go_s = nak_q ? S_IDLE : S_F_ACK_END;
                else go_s = S_IDLE;
              end else begin
                unique case (state_q)
                  S_I_HINIT_HI, S_I_HDST_HI, S_I_DATA_HI: begin
                    txbit_d = txbit_q + 3'd1;
                    if (txbit_d == 3'd0 && txbyte_q < MAX_POS) begin
                      txbyte_d = txbyte_q + BYTE_POS_W'(1);
                    end
                    if (state_q == S_I_HINIT_HI) begin
                      go_s = (txbit_d == 3'd4) ? S_I_HDST_LO : S_I_HINIT_LO;
                    end else if (state_q == S_I_HDST_HI) begin
                      go_s = (txbyte_d == BYTE_POS_W'(1)) ? S_I_EOM_LO : S_I_HDST_LO;
                    end else begin
                      go_s = (txbit_d == 3'd0) ? S_I_EOM_LO : S_I_DATA_LO;
                    end
                  end
                  S_I_EOM_HI: go_s = S_I_ACK_LO;
                  S_I_ACK_CHK: begin
                    if (ack_q && !(txbit_q == 3'd0 && txbyte_q == pend_q)) begin
                      go_s = S_I_DATA_LO;
                    end else if (ack_q) begin
                      pend_d = '0; resend_d = '0; res_o.send_status = ST_DONE;
                      go_s = S_IDLE;
                    end else if (resend_q < MAX_RS) begin
                      resend_d = resend_q + 3'd1; go_s = S_I_FREE;
                    end else begin
                      pend_d = '0; resend_d = '0; res_o.send_status = ST_FAIL;
                      go_s = S_IDLE;
                    end
                  end
                  default: go_s = state_q + 5'd1;
                endcase
              end
            end
          end
        end
        CMD_START: begin
          if (state_q == S_OFF || pend_q != '0 || item_i.frame_length == '0
              || item_i.frame_length > MAX_POS) begin
            res_o.start_refused = 1'b1;
          end else begin
            pend_d = item_i.frame_length;
            if (state_q == S_IDLE) begin
              go_en = 1'b1; go_s = S_I_FREE;
            end
          end
        end
        default: ;
      endcase
    end

    if (go_en) begin
      s = go_s;
      if (s == S_F_ACK_LO && hdr_d[3:0] != own_q && hdr_d[3:0] != ADDR_ALL) s = S_IDLE;
      if (s == S_IDLE) begin
        txbit_d = '0; txbyte_d = '0; rxbit_d = '0; rxbyte_d = '0;
        if (pend_d != '0) s = S_I_FREE;
      end
      state_d = s;
      tb = (txbyte_d >= MAX_POS) ? 1'b0
         : tx_buf_q[txbyte_d[BYTE_IDX_W-1:0]][3'd7 - txbit_d];
      at_end = (txbit_d == 3'd0) && (txbyte_d == pend_d);
      b = !item_i.line_level ^ (tx_buf_q[0][3:0] == ADDR_ALL);
      elapsed_d = '0;
      unique case (s)
        S_OFF: begin
          drv_d = 1'b0; hdr_d = '0; shift_d = '0; lowdur_d = '0;
          txbit_d = '0; txbyte_d = '0; rxbit_d = '0; rxbyte_d = '0;
          pend_d = '0; resend_d = '0; ack_d = 1'b0; eom_d = 1'b0; nak_d = 1'b0;
          timeout_d = '0; cap_d = CAP_OFF;
        end
        S_IDLE: begin
          drv_d = 1'b0; timeout_d = '0; cap_d = CAP_FALL;
        end
        S_I_FREE: begin
          drv_d = 1'b0; cap_d = CAP_FALL;
          timeout_d = (resend_d != '0) ? tk_i.t72 : tk_i.t120;
        end
        S_I_START_LO: begin
          txbit_d = '0; txbyte_d = '0; drv_d = 1'b1; timeout_d = tk_i.t37;
        end
        S_I_START_HI: begin
          drv_d = 1'b0; timeout_d = tk_i.t8; cap_d = CAP_FALL;
        end
        S_I_HINIT_LO, S_I_HDST_LO, S_I_DATA_LO: begin
          drv_d = 1'b1; timeout_d = tb ? tk_i.t6 : tk_i.t15;
        end
        S_I_HINIT_HI: begin
          drv_d = 1'b0; timeout_d = tb ? tk_i.t18 : tk_i.t9; cap_d = CAP_FALL;
        end
        S_I_HDST_HI, S_I_DATA_HI: begin
          drv_d = 1'b0; timeout_d = tb ? tk_i.t18 : tk_i.t9;
        end
        S_I_EOM_LO: begin
          drv_d = 1'b1; timeout_d = at_end ? tk_i.t6 : tk_i.t15;
        end
        S_I_EOM_HI: begin
          drv_d = 1'b0; timeout_d = at_end ? tk_i.t18 : tk_i.t9;
        end
        S_I_ACK_LO: begin
          drv_d = 1'b1; timeout_d = tk_i.t6;
        end
        S_I_ACK_HI: begin
          drv_d = 1'b0; timeout_d = tk_i.t4h;
        end
        S_I_ACK_CHK: begin
          ack_d = b; timeout_d = tk_i.t14mh;
        end
        S_F_START_LO: begin
          timeout_d = tk_i.t40; cap_d = CAP_RISE;
        end
        S_F_START_HI: begin
          timeout_d = tk_i.t23; cap_d = CAP_FALL;
        end
        S_F_HINIT_LO, S_F_HDST_LO, S_F_EOM_LO, S_F_DATA_LO: begin
          timeout_d = tk_i.t18; cap_d = CAP_RISE;
        end
        S_F_HINIT_HI, S_F_HDST_HI, S_F_EOM_HI, S_F_DATA_HI: begin
          timeout_d = tk_i.t24h; cap_d = CAP_FALL;
        end
        S_F_ACK_LO: begin
          if (hdr_d[3:0] == own_q) drv_d = 1'b1;
          timeout_d = tk_i.t10h;
        end
        S_F_ACK_CHK: begin
          nak_d = (hdr_d[3:0] == ADDR_ALL) && !item_i.line_level;
          timeout_d = tk_i.t5mh;
        end
        S_F_ACK_END: begin
          drv_d = 1'b0;
          res_o.rx_valid = 1'b1; res_o.rx_data = shift_d; res_o.rx_last = eom_d;
          if (eom_d || rxbyte_d >= MAX_POS) begin
            timeout_d = tk_i.t9;
          end else begin
            timeout_d = tk_i.t24h; cap_d = CAP_FALL;
          end
        end
        default: ;
      endcase
    end
    res_o.line_release = !drv_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_OFF;    elapsed_q <= '0; timeout_q <= '0; lowdur_q <= '0;
      cap_q    <= CAP_OFF;  prev_q    <= 1'b1;
      hdr_q    <= '0;       shift_q   <= '0;
      txbit_q  <= '0;       rxbit_q   <= '0; resend_q  <= '0;
      txbyte_q <= '0;       rxbyte_q  <= '0; pend_q    <= '0;
      ack_q    <= 1'b0;     eom_q     <= 1'b0; nak_q   <= 1'b0; drv_q <= 1'b0;
      own_q    <= 4'd5;     tpu_q     <= CFG_DATA_W'(100);
    end else begin
      state_q  <= state_d;  elapsed_q <= elapsed_d; timeout_q <= timeout_d;
      lowdur_q <= lowdur_d; cap_q     <= cap_d;     prev_q    <= prev_d;
      hdr_q    <= hdr_d;    shift_q   <= shift_d;
      txbit_q  <= txbit_d;  rxbit_q   <= rxbit_d;   resend_q  <= resend_d;
      txbyte_q <= txbyte_d; rxbyte_q  <= rxbyte_d;  pend_q    <= pend_d;
      ack_q    <= ack_d;    eom_q     <= eom_d;     nak_q     <= nak_d;   drv_q <= drv_d;
      own_q    <= own_d;    tpu_q     <= tpu_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (buf_clr) begin
      for (int i = 0; i < MAX_MSG_BYTES; i++) begin
        tx_buf_q[i] <= '0;
      end
    end else if (buf_we) begin
      tx_buf_q[item_i.byte_slot[BYTE_IDX_W-1:0]] <= item_i.byte_value;
    end
  end

`ifndef SYNTHESIS
  a_off_released: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_OFF) |-> (!drv_q && timeout_q == '0 && pend_q == '0))
    else $error("disabled controller holds state");
  a_pend_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q <= MAX_POS)
    else $error("pending length out of range");
  a_resend_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    resend_q <= MAX_RS)
    else $error("resend count out of range");
  a_tpu_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tpu_q != '0)
    else $error("tick scale is zero");
`endif

endmodule

[sv/cec_bus_controller.sv]
// CEC bus controller, one tick item per clock cycle while in_ready_o is high.
// Input channel (in_valid_i/in_ready_o, in_data_i): each transfer carries a
// command: a timer tick with the sampled bus level, a transmit buffer write,
// or a start of send with the frame length.
// Output channel (out_valid_o/out_ready_i, out_data_o): one result per input
// transfer, in order: line drive, send status, start refusal and any
// completed received byte.
// Configuration: cfg_we_i writes cfg_data_i to register cfg_idx_i
// (0 enable, 1 own address, 2 ticks per 100 us) at the clock edge.
// A result is registered into the result queue with its input transfer. Throughput:
// one item per cycle; all work for an item is one pass through the state
// update logic between the state registers and a two-entry result queue.
// When the receiver stalls, the queue absorbs up to two results; in_ready_o
// drops only while both entries are held, and resumes as soon as one drains.
// Reset: disabled, line released, own address 5, 100 ticks per 100 us,
// result queue empty. The transmit buffer has no reset.
module cec_bus_controller (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  cbc_pkg::in_t                   in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output cbc_pkg::out_t                  out_data_o,
  input  logic                           cfg_we_i,
  input  logic [cbc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [cbc_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import cbc_pkg::*;

  logic                  acc;
  logic                  full;
  out_t                  res;
  tk_t                   tk;
  logic [CFG_DATA_W-1:0] tpu;

  assign in_ready_o = !full;
  assign acc        = in_valid_i && !full;

  cbc_timing u_timing (
    .tpu_i (tpu),
    .tk_o  (tk)
  );

  cbc_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .acc_i      (acc),
    .item_i     (in_data_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .tk_i       (tk),
    .tpu_o      (tpu),
    .res_o      (res)
  );

  cbc_outbuf u_outbuf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (acc),
    .data_i  (res),
    .full_o  (full),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .data_o  (out_data_o)
  );

endmodule

[verif/cec_bus_checker.sv]
module cec_bus_checker
  import cbc_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  input  logic                   in_ready_i,
  input  in_t                    in_data_i,
  input  logic                   out_valid_i,
  input  logic                   out_ready_i,
  input  out_t                   out_data_i,
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i,
  output int                     fail_count_o,
  output int                     outstanding_o
);

  typedef enum logic [4:0] {
    CS_OFF, CS_IDLE, CS_I_FREE, CS_I_START_LO, CS_I_START_HI, CS_I_HINIT_LO, CS_I_HINIT_HI,
    CS_I_HDST_LO, CS_I_HDST_HI, CS_I_DATA_LO, CS_I_DATA_HI, CS_I_EOM_LO, CS_I_EOM_HI,
    CS_I_ACK_LO, CS_I_ACK_HI, CS_I_ACK_CHK, CS_F_START_LO, CS_F_START_HI, CS_F_HINIT_LO,
    CS_F_HINIT_HI, CS_F_HDST_LO, CS_F_HDST_HI, CS_F_EOM_LO, CS_F_EOM_HI, CS_F_ACK_LO,
    CS_F_ACK_CHK, CS_F_ACK_END, CS_F_DATA_LO, CS_F_DATA_HI
  } cec_state_e;

  typedef enum logic [1:0] {CAP_OFF, CAP_FALL, CAP_RISE, CAP_KEEP} capture_e;

  localparam longint CNT_MAX = (longint'(1) << TICK_W) - 1;

  logic             enabled;
  logic [3:0]       own_addr;
  logic [11:0]      ticks_per_100us;
  cec_state_e       st;
  capture_e         cap;
  longint           elapsed, limit_ticks, low_dur;
  logic             prev_lvl, line_now;
  logic [7:0]       tx_buf [MAX_MSG_BYTES];
  logic [7:0]       rx_header, rx_shift;
  logic [2:0]       tx_bit, rx_bit;
  int               tx_byte, rx_byte, pend_len, resends;
  logic             f_ack, f_eom, f_nak, drive_low;
  logic [1:0]       o_status;
  logic             o_valid, o_last;
  logic [7:0]       o_data;
  out_t             result_q[$];

  assign outstanding_o = result_q.size();

  function automatic longint tk(longint us);
    longint t;
    t = (ticks_per_100us == 0) ? 1 : ticks_per_100us;
    return us * t / 100;
  endfunction

  function automatic void arm(longint t, capture_e mode);
    limit_ticks = (t > CNT_MAX) ? CNT_MAX : t;
    elapsed = 0;
    if (mode != CAP_KEEP) cap = mode;
  endfunction

  function automatic logic tx_bit_val();
    if (tx_byte >= MAX_MSG_BYTES) return 1'b0;
    return tx_buf[tx_byte][3'd7 - tx_bit];
  endfunction

  function automatic logic tx_end();
    return tx_bit == 0 && tx_byte == pend_len;
  endfunction

  function automatic longint low_us(logic b);
    return b ? 600 : 1500;
  endfunction

  function automatic longint high_us(logic b);
    return b ? 1800 : 900;
  endfunction

  function automatic void tx_next();
    tx_bit = tx_bit + 3'd1;
    if (tx_bit == 0 && tx_byte < MAX_MSG_BYTES) tx_byte++;
  endfunction

  function automatic void rx_next();
    rx_bit = rx_bit + 3'd1;
    if (rx_bit == 0) begin
      if (rx_byte == 0) rx_header = rx_shift;
      if (rx_byte < MAX_MSG_BYTES) rx_byte++;
    end
  endfunction

  function automatic logic in_low(longint lo, longint hi, longint t);
    return t + tk(100) >= tk(lo) && t <= tk(hi) + tk(100);
  endfunction

  function automatic logic in_sum(longint lo, longint hi, longint t);
    longint s;
    s = low_dur + t;
    return s <= tk(hi) + tk(100) && s + tk(100) >= tk(lo);
  endfunction

  function automatic void enter(cec_state_e s);
    logic again;
    again = 1'b1;
    while (again) begin
      again = 1'b0;
      st = s;
      case (s)
        CS_OFF: begin
          drive_low = 0; rx_header = 0; rx_shift = 0; low_dur = 0;
          tx_bit = 0; tx_byte = 0; rx_bit = 0; rx_byte = 0;
          pend_len = 0; resends = 0; f_ack = 0; f_eom = 0; f_nak = 0;
          foreach (tx_buf[i]) tx_buf[i] = '0;
          arm(0, CAP_OFF);
        end
        CS_IDLE: begin
          tx_bit = 0; tx_byte = 0; rx_bit = 0; rx_byte = 0;
          if (pend_len > 0) begin
            s = CS_I_FREE;
            again = 1'b1;
          end else begin
            drive_low = 0;
            arm(0, CAP_FALL);
          end
        end
        CS_I_FREE: begin
          drive_low = 0;
          arm((resends != 0 ? 3 : 5) * tk(2400), CAP_FALL);
        end
        CS_I_START_LO: begin
          tx_bit = 0; tx_byte = 0; drive_low = 1;
          arm(tk(3700), CAP_KEEP);
        end
        CS_I_START_HI: begin
          drive_low = 0;
          arm(tk(800), CAP_FALL);
        end
        CS_I_HINIT_LO, CS_I_HDST_LO, CS_I_DATA_LO: begin
          drive_low = 1;
          arm(tk(low_us(tx_bit_val())), CAP_KEEP);
        end
        CS_I_HINIT_HI: begin
          drive_low = 0;
          arm(tk(high_us(tx_bit_val())), CAP_FALL);
        end
        CS_I_HDST_HI, CS_I_DATA_HI: begin
          drive_low = 0;
          arm(tk(high_us(tx_bit_val())), CAP_KEEP);
        end
        CS_I_EOM_LO: begin
          drive_low = 1;
          arm(tk(low_us(tx_end())), CAP_KEEP);
        end
        CS_I_EOM_HI: begin
          drive_low = 0;
          arm(tk(high_us(tx_end())), CAP_KEEP);
        end
        CS_I_ACK_LO: begin
          drive_low = 1;
          arm(tk(600), CAP_KEEP);
        end
        CS_I_ACK_HI: begin
          drive_low = 0;
          arm((tk(600) + tk(1500)) / 2 - tk(600), CAP_KEEP);
        end
        CS_I_ACK_CHK: begin
          f_ack = !line_now ^ (tx_buf[0][3:0] == ADDR_ALL);
          arm(tk(2400) - tk(1050), CAP_KEEP);
        end
        CS_F_START_LO: arm(tk(3900) + tk(100), CAP_RISE);
        CS_F_START_HI: arm(tk(5700) - tk(3500) + tk(100), CAP_FALL);
        CS_F_HINIT_LO, CS_F_HDST_LO, CS_F_EOM_LO, CS_F_DATA_LO:
          arm(tk(1700) + tk(100), CAP_RISE);
        CS_F_HINIT_HI, CS_F_HDST_HI, CS_F_EOM_HI, CS_F_DATA_HI:
          arm(tk(2750) - tk(400) + tk(100), CAP_FALL);
        CS_F_ACK_LO: begin
          if (rx_header[3:0] == own_addr) begin
            drive_low = 1;
            arm(tk(1050), CAP_KEEP);
          end else if (rx_header[3:0] == ADDR_ALL) begin
            arm(tk(1050), CAP_KEEP);
          end else begin
            s = CS_IDLE;
            again = 1'b1;
          end
        end
        CS_F_ACK_CHK: begin
          f_nak = (rx_header[3:0] == ADDR_ALL) && !line_now;
          arm(tk(1500) - tk(1050), CAP_KEEP);
        end
        CS_F_ACK_END: begin
          drive_low = 0;
          o_valid = 1; o_data = rx_shift; o_last = f_eom;
          if (f_eom || rx_byte >= MAX_MSG_BYTES) arm(tk(900), CAP_KEEP);
          else arm(tk(2750) - tk(400) + tk(100), CAP_FALL);
        end
        default: ;
      endcase
    end
  endfunction

  function automatic logic on_capture();
    longint t;
    logic b;
    t = elapsed;
    case (st)
      CS_IDLE: enter(CS_F_START_LO);
      CS_I_FREE, CS_I_START_HI, CS_I_HINIT_HI: begin
        tx_bit = 0; tx_byte = 0;
        enter(CS_F_START_LO);
      end
      CS_F_START_LO: begin
        if (in_low(3500, 3900, t)) begin
          low_dur = t;
          enter(CS_F_START_HI);
        end else enter(CS_IDLE);
      end
      CS_F_START_HI: enter(in_sum(4300, 5700, t) ? CS_F_HINIT_LO : CS_IDLE);
      CS_F_HINIT_LO, CS_F_HDST_LO, CS_F_DATA_LO, CS_F_EOM_LO: begin
        if (in_low(1300, 1700, t) || in_low(400, 800, t)) begin
          b = !in_low(1300, 1700, t);
          low_dur = t;
          if (st == CS_F_EOM_LO) f_eom = b;
          else rx_shift = {rx_shift[6:0], b};
          enter(cec_state_e'(st + 5'd1));
        end else enter(CS_IDLE);
      end
      CS_F_HINIT_HI, CS_F_HDST_HI, CS_F_DATA_HI: begin
        if (!in_sum(2050, 2750, t)) enter(CS_IDLE);
        else begin
          rx_next();
          if (st == CS_F_HINIT_HI) enter(rx_bit == 4 ? CS_F_HDST_LO : CS_F_HINIT_LO);
          else if (rx_bit == 0) enter(CS_F_EOM_LO);
          else enter(st == CS_F_HDST_HI ? CS_F_HDST_LO : CS_F_DATA_LO);
        end
      end
      CS_F_EOM_HI: enter(in_sum(2050, 2750, t) ? CS_F_ACK_LO : CS_IDLE);
      CS_F_ACK_LO: enter(CS_F_ACK_END);
      CS_F_ACK_END: enter(CS_F_DATA_LO);
      default: return 1'b0;
    endcase
    return 1'b1;
  endfunction

  function automatic void on_timeout();
    cec_state_e s;
    s = st;
    if (s == CS_OFF || s == CS_IDLE) return;
    if (s >= CS_F_START_LO) begin
      if (s == CS_F_ACK_LO) enter(CS_F_ACK_CHK);
      else if (s == CS_F_ACK_CHK) enter(f_nak ? CS_IDLE : CS_F_ACK_END);
      else enter(CS_IDLE);
      return;
    end
    case (s)
      CS_I_HINIT_HI: begin
        tx_next();
        enter(tx_bit == 4 ? CS_I_HDST_LO : CS_I_HINIT_LO);
      end
      CS_I_HDST_HI: begin
        tx_next();
        enter(tx_byte == 1 ? CS_I_EOM_LO : CS_I_HDST_LO);
      end
      CS_I_DATA_HI: begin
        tx_next();
        enter(tx_bit == 0 ? CS_I_EOM_LO : CS_I_DATA_LO);
      end
      CS_I_EOM_HI: enter(CS_I_ACK_LO);
      CS_I_ACK_CHK: begin
        if (f_ack) begin
          if (!tx_end()) enter(CS_I_DATA_LO);
          else begin
            pend_len = 0; resends = 0; o_status = ST_DONE;
            enter(CS_IDLE);
          end
        end else if (resends < MAX_RESENDS) begin
          resends++;
          enter(CS_I_FREE);
        end else begin
          pend_len = 0; resends = 0; o_status = ST_FAIL;
          enter(CS_IDLE);
        end
      end
      default: enter(cec_state_e'(s + 5'd1));
    endcase
  endfunction

  function automatic void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    case (idx)
      CFG_ENABLE: begin
        enabled = val[0];
        if (enabled && st == CS_OFF) enter(CS_IDLE);
        else if (!enabled && st != CS_OFF) enter(CS_OFF);
      end
      CFG_OWN: own_addr = val[3:0];
      CFG_TICKS: ticks_per_100us = val[11:0];
      default: ;
    endcase
  endfunction

  function automatic out_t predict(in_t it);
    out_t r;
    logic refused, fall, rise, hit, done;
    refused = 0;
    o_status = ST_NONE; o_valid = 0; o_data = '0; o_last = 0;
    case (it.command)
      CMD_TICK: begin
        fall = prev_lvl && !it.line_level;
        rise = !prev_lvl && it.line_level;
        line_now = it.line_level;
        prev_lvl = it.line_level;
        if (elapsed < CNT_MAX) elapsed++;
        if (st != CS_OFF) begin
          hit = (cap == CAP_FALL && fall) || (cap == CAP_RISE && rise);
          done = hit ? on_capture() : 1'b0;
          if (!done && limit_ticks != 0 && elapsed >= limit_ticks) on_timeout();
        end
      end
      CMD_WRITE: if (pend_len == 0) tx_buf[it.byte_slot] = it.byte_value;
      CMD_START: begin
        if (st == CS_OFF || pend_len != 0 || it.frame_length == 0 ||
            it.frame_length > MAX_MSG_BYTES) begin
          refused = 1;
        end else begin
          pend_len = it.frame_length;
          if (st == CS_IDLE) enter(CS_I_FREE);
        end
      end
      default: ;
    endcase
    r.line_release  = !drive_low;
    r.send_status   = o_status;
    r.start_refused = refused;
    r.rx_valid      = o_valid;
    r.rx_data       = o_data;
    r.rx_last       = o_last;
    return r;
  endfunction

  task automatic report(string field, logic [7:0] want, logic [7:0] got);
    $display("%0t mismatch %s: expected %0h actual %0h", $time, field, want, got);
    fail_count_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    out_t want;
    if (!rst_ni) begin
      result_q.delete();
      fail_count_o = 0;
      enabled = 0; own_addr = 4'd5; ticks_per_100us = 12'd100;
      prev_lvl = 1; line_now = 1; cap = CAP_OFF;
      enter(CS_OFF);
    end else begin
      if (cfg_we_i) write_reg(cfg_idx_i, cfg_data_i);
      if (out_valid_i && out_ready_i) begin
        if (result_q.size() == 0) begin
          $display("%0t unexpected transfer: actual %0h", $time, out_data_i);
          fail_count_o++;
        end else begin
          want = result_q.pop_front();
          if (want.line_release != out_data_i.line_release)
            report("line_release", want.line_release, out_data_i.line_release);
          if (want.send_status != out_data_i.send_status)
            report("send_status", want.send_status, out_data_i.send_status);
          if (want.start_refused != out_data_i.start_refused)
            report("start_refused", want.start_refused, out_data_i.start_refused);
          if (want.rx_valid != out_data_i.rx_valid)
            report("rx_valid", want.rx_valid, out_data_i.rx_valid);
          if (want.rx_data != out_data_i.rx_data)
            report("rx_data", want.rx_data, out_data_i.rx_data);
          if (want.rx_last != out_data_i.rx_last)
            report("rx_last", want.rx_last, out_data_i.rx_last);
        end
      end
      if (in_valid_i && in_ready_i) result_q.push_back(predict(in_data_i));
    end
  end

endmodule

[verif/cec_bus_controller_test.sv]
module cec_bus_controller_test;
  import cbc_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int TOTAL_ITEMS = 1950;

  logic                  clk, rst_n;
  logic                  in_valid, in_ready, out_valid, out_ready, cfg_we;
  in_t                   in_data;
  out_t                  out_data;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;
  int                    fail_count, outstanding;
  int                    sent = 0;
  int                    cycles = 0;
  int                    tpc = 100;
  logic [3:0]            own = 4'd5;
  logic                  calm = 0;
  logic                  hold_req = 0;

  cec_bus_controller dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_o(in_ready), .in_data_i(in_data),
    .out_valid_o(out_valid), .out_ready_i(out_ready), .out_data_o(out_data),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data)
  );

  cec_bus_checker checker_i (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_i(in_ready), .in_data_i(in_data),
    .out_valid_i(out_valid), .out_ready_i(out_ready), .out_data_i(out_data),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data),
    .fail_count_o(fail_count), .outstanding_o(outstanding)
  );

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    out_ready = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ready = 0;
        repeat (400) @(negedge clk);
        hold_req = 0;
      end
      out_ready = calm || ($urandom_range(99) >= 10);
    end
  end

  function automatic in_t mk_tick(logic lv);
    in_t it;
    it = in_t'($urandom);
    it.command = CMD_TICK;
    it.line_level = lv;
    return it;
  endfunction

  function automatic in_t mk_write(int slot, int val);
    in_t it;
    it = in_t'($urandom);
    it.command = CMD_WRITE;
    it.byte_slot = 4'(slot);
    it.byte_value = 8'(val);
    return it;
  endfunction

  function automatic in_t mk_start(int len);
    in_t it;
    it = in_t'($urandom);
    it.command = CMD_START;
    it.frame_length = 5'(len);
    return it;
  endfunction

  function automatic int dur(int us);
    return us * tpc / 100;
  endfunction

  task automatic offer(in_t it);
    @(negedge clk);
    while (!calm && $urandom_range(99) < 10) begin
      in_valid = 0;
      @(negedge clk);
    end
    in_valid = 1;
    in_data = it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent++;
  endtask

  task automatic ticks(int n, logic lv);
    repeat (n) offer(mk_tick(lv));
  endtask

  task automatic quiesce();
    @(negedge clk);
    in_valid = 0;
    wait (outstanding == 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int val);
    @(negedge clk);
    cfg_we = 1;
    cfg_idx = idx;
    cfg_data = CFG_DATA_W'(val);
    @(negedge clk);
    cfg_we = 0;
  endtask

  task automatic configure(int addr, int ticks_cfg);
    quiesce();
    write_reg(CFG_ENABLE, 0);
    write_reg(CFG_OWN, addr);
    write_reg(CFG_TICKS, ticks_cfg);
    write_reg(CFG_ENABLE, 1);
    own = 4'(addr);
    tpc = ticks_cfg;
    for (int s = 0; s < MAX_MSG_BYTES; s++) offer(mk_write(s, $urandom));
  endtask

  task automatic cec_bit(logic v);
    int lo, tot;
    lo = v ? dur(600) : dur(1500);
    tot = dur(2400);
    if ($urandom_range(29) == 0) lo = lo + $urandom_range(2) - 1;
    if ($urandom_range(59) == 0) lo = $urandom_range(1, 30);
    if (lo < 1) lo = 1;
    ticks(lo, 0);
    ticks((tot - lo < 1) ? 1 : tot - lo, 1);
  endtask

  task automatic rx_frame(int nbytes, logic [3:0] dst);
    logic [7:0] b;
    ticks(dur(3700), 0);
    ticks(dur(4500) - dur(3700), 1);
    for (int i = 0; i < nbytes; i++) begin
      b = (i == 0) ? {4'($urandom), dst} : 8'($urandom);
      for (int k = 7; k >= 0; k--) cec_bit(b[k]);
      cec_bit(i == nbytes - 1);
      cec_bit($urandom_range(1));
    end
    ticks($urandom_range(20, 60), 1);
  endtask

  task automatic tx_burst(int len);
    repeat ($urandom_range(3)) offer(mk_write($urandom_range(15), $urandom));
    offer(mk_start(len));
    repeat ($urandom_range(100, 250) * tpc) offer(mk_tick($urandom_range(99) >= 3));
  endtask

  function automatic logic [3:0] pick_dst();
    case ($urandom_range(3))
      0: return own;
      1: return ADDR_ALL;
      2: return 4'($urandom);
      default: return own;
    endcase
  endfunction

  task automatic random_phase(int n_items);
    int stop;
    stop = sent + n_items;
    while (sent < stop) begin
      case ($urandom_range(19)) inside
        [0:9]:   rx_frame($urandom_range(1, 2), pick_dst());
        [10:13]: tx_burst(($urandom_range(19) == 0) ? 16 : $urandom_range(1, 4));
        [14:16]: repeat ($urandom_range(1, 8)) begin
          in_t it;
          it = in_t'($urandom);
          it.command = 2'($urandom_range(2));
          offer(it);
        end
        default: ticks($urandom_range(5, 40), 1);
      endcase
    end
  endtask

  initial begin
    rst_n = 0;
    in_valid = 0;
    in_data = '0;
    cfg_we = 0;
    cfg_idx = '0;
    cfg_data = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    offer(mk_tick(0));
    offer(mk_start(1));
    offer(mk_write(15, 8'hff));
    offer(mk_tick(1));

    configure(0, 1);
    offer(mk_write(0, 8'h00));
    offer(mk_write(15, 8'hff));
    offer(mk_start(0));
    offer(mk_start(17));
    offer(mk_start(31));
    offer(mk_start(16));
    offer(mk_start(1));
    offer(mk_write(3, 8'hff));
    ticks(60, 1);

    configure(0, 1);
    rx_frame(1, 4'd0);
    rx_frame(2, ADDR_ALL);
    tx_burst(1);

    configure(14, 4095);
    offer(mk_start(1));
    ticks(20, 1);
    ticks(5, 0);

    configure(15, 1);
    random_phase(80);

    configure(14, 1);
    hold_req = 1;
    random_phase(80);

    configure(0, 1);
    calm = 1;
    random_phase(80);
    calm = 0;

    configure(7, 1);
    if (sent < TOTAL_ITEMS) random_phase(TOTAL_ITEMS - sent);

    quiesce();
    repeat (10) @(negedge clk);
    if (fail_count == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
